### hw/rtl/ltc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_pkg: shared types and constants of the literal token classifier
// Character classes, kind and error codes, and the per-token state record.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_WORD  = 3'd1;
    localparam logic [2:0] KIND_DEC   = 3'd2;
    localparam logic [2:0] KIND_BIN   = 3'd3;
    localparam logic [2:0] KIND_HEX   = 3'd4;
    localparam logic [2:0] KIND_FLOAT = 3'd5;

    localparam logic [2:0] ERR_OK         = 3'd0;
    localparam logic [2:0] ERR_WORD       = 3'd1;
    localparam logic [2:0] ERR_FLOAT_PRE  = 3'd2;
    localparam logic [2:0] ERR_FLOAT_POST = 3'd3;
    localparam logic [2:0] ERR_BIN        = 3'd4;
    localparam logic [2:0] ERR_HEX        = 3'd5;
    localparam logic [2:0] ERR_DEC        = 3'd6;

    localparam logic [1:0] LEAD_OTHER = 2'd0;
    localparam logic [1:0] LEAD_ALPHA = 2'd1;
    localparam logic [1:0] LEAD_DIGIT = 2'd2;
    localparam logic [1:0] LEAD_ZERO  = 2'd3;

    localparam logic [1:0] MODE_DEC = 2'd0;
    localparam logic [1:0] MODE_BIN = 2'd1;
    localparam logic [1:0] MODE_HEX = 2'd2;

    // error flag bit positions
    localparam logic [1:0] FLAG_PRE  = 2'd0;
    localparam logic [1:0] FLAG_POST = 2'd1;
    localparam logic [1:0] FLAG_BIN  = 2'd2;
    localparam logic [1:0] FLAG_HEX  = 2'd3;

    localparam logic [1:0] POS_LAST = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;

    typedef struct packed {
        logic [1:0] position;
        logic [1:0] lead_class;
        logic [1:0] prefix_mode;
        logic       dot_seen;
        logic [3:0] error_flags;
    } tok_state_t;

    function automatic logic is_digit(input logic [7:0] ch);
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] ch);
        is_letter = ((ch >= CH_LC_A) && (ch <= CH_LC_Z)) ||
                    ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) || (ch == CH_UNDER);
    endfunction

    function automatic logic is_hex(input logic [7:0] ch);
        is_hex = is_digit(ch) || ((ch >= CH_LC_A) && (ch <= CH_LC_F)) ||
                 ((ch >= CH_UC_A) && (ch <= CH_UC_F));
    endfunction

endpackage

### hw/rtl/ltc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_step: one character step of the classifier
// Folds one character into the token state and decodes kind and error.
// ----------------------------------------------------------------------------
module ltc_step (
    input  ltc_pkg::tok_state_t cur,
    input  logic [7:0]          ch,
    input  logic                last,
    output ltc_pkg::tok_state_t nxt,
    output logic [2:0]          kind,
    output logic [2:0]          error
);
    import ltc_pkg::*;

    tok_state_t upd;

    always_comb begin
        upd = cur;
        if (cur.position == 2'd0) begin
            if (is_letter(ch)) begin
                upd.lead_class = LEAD_ALPHA;
            end else if (ch == CH_ZERO) begin
                upd.lead_class = LEAD_ZERO;
            end else if (is_digit(ch)) begin
                upd.lead_class = LEAD_DIGIT;
            end else begin
                upd.lead_class = LEAD_OTHER;
            end
        end else if (cur.lead_class == LEAD_ALPHA) begin
            if (!is_letter(ch) && !is_digit(ch)) begin
                upd.error_flags[FLAG_PRE] = 1'b1;
            end
        end else if (cur.lead_class != LEAD_OTHER) begin
            if (ch == CH_DOT && !cur.dot_seen) begin
                upd.dot_seen = 1'b1;
            end else if (!is_digit(ch)) begin
                // a second dot lands here too
                if (cur.dot_seen) begin
                    upd.error_flags[FLAG_POST] = 1'b1;
                end else begin
                    upd.error_flags[FLAG_PRE] = 1'b1;
                end
            end
            if (cur.position == 2'd1) begin
                if (cur.lead_class == LEAD_ZERO && ch == CH_LC_B) begin
                    upd.prefix_mode = MODE_BIN;
                end else if (cur.lead_class == LEAD_ZERO && ch == CH_LC_X) begin
                    upd.prefix_mode = MODE_HEX;
                end
            end else begin
                if (ch != CH_ZERO && ch != CH_ONE) begin
                    upd.error_flags[FLAG_BIN] = 1'b1;
                end
                if (!is_hex(ch)) begin
                    upd.error_flags[FLAG_HEX] = 1'b1;
                end
            end
        end
        if (cur.position != POS_LAST) begin
            upd.position = cur.position + 2'd1;
        end
    end

    always_comb begin
        kind  = KIND_NONE;
        error = ERR_OK;
        if (upd.lead_class == LEAD_ALPHA) begin
            if (upd.error_flags[FLAG_PRE]) begin
                error = ERR_WORD;
            end else begin
                kind = KIND_WORD;
            end
        end else if (upd.lead_class != LEAD_OTHER) begin
            if (upd.dot_seen) begin
                if (upd.error_flags[FLAG_PRE]) begin
                    error = ERR_FLOAT_PRE;
                end else if (upd.error_flags[FLAG_POST]) begin
                    error = ERR_FLOAT_POST;
                end else begin
                    kind = KIND_FLOAT;
                end
            end else if (upd.prefix_mode == MODE_BIN) begin
                if (upd.error_flags[FLAG_BIN]) begin
                    error = ERR_BIN;
                end else begin
                    kind = KIND_BIN;
                end
            end else if (upd.prefix_mode == MODE_HEX) begin
                if (upd.error_flags[FLAG_HEX]) begin
                    error = ERR_HEX;
                end else begin
                    kind = KIND_HEX;
                end
            end else begin
                if (upd.error_flags[FLAG_PRE]) begin
                    error = ERR_DEC;
                end else begin
                    kind = KIND_DEC;
                end
            end
        end
    end

    // the token ends here: start clean for the next one
    assign nxt = last ? '0 : upd;

endmodule

### hw/rtl/literal_token_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_token_classifier: numeric literal lexer
// Classifies a token fed one character per word; one result per token.
// ----------------------------------------------------------------------------
// channel  | direction | ports                              | word
// s_       | in        | s_valid s_ready s_character s_last_char | one character
// m_       | out       | m_valid m_ready m_kind m_error     | one token result
//
// One character per cycle while no last character waits on a full result
// register; a token's result is registered as its last character is consumed.
// Path: input register -> step logic and token state -> result register.
// Reset (aresetn low, synchronous) empties both registers and clears the token.
// A stalled m_ready holds the result; characters keep flowing until a last
// character meets a full result register, which stalls s_ready.
// ----------------------------------------------------------------------------
module literal_token_classifier (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [2:0] m_error
);
    import ltc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    tok_state_t tok_reg;
    tok_state_t tok_next;
    logic       m_valid_reg;
    logic [2:0] m_kind_reg;
    logic [2:0] m_error_reg;
    logic [2:0] step_kind;
    logic [2:0] step_error;
    logic       out_free;
    logic       consume;

    assign out_free = !m_valid_reg || m_ready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || consume;

    ltc_step u_step (
        .cur   (tok_reg),
        .ch    (in_char_reg),
        .last  (in_last_reg),
        .nxt   (tok_next),
        .kind  (step_kind),
        .error (step_error)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_character;
            in_last_reg <= s_last_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else if (consume) begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= consume && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_last_reg) begin
            m_kind_reg  <= step_kind;
            m_error_reg <= step_error;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_error = m_error_reg;

endmodule

### hw/rtl/ltc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltc_checker: port-level checks of the literal token classifier
// Watches the input and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module ltc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_kind,
    input logic [2:0] m_error
);
    import ltc_pkg::*;

    // a held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_error))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // any error forces kind none
    a_err_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error != ERR_OK) |-> m_kind == KIND_NONE)
        else $error("error result with a kind");

    // input side never stalls while the result register is empty
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // a draining result register always frees the input
    a_ready_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind literal_token_classifier ltc_checker u_ltc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_kind  (m_kind),
    .m_error (m_error)
);

### dv/literal_token_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// literal_token_classifier_test: testbench of the literal token classifier
// Streams tokens a character at a time: a directed set, then random tokens
// that are mostly well-formed words and literals with some corruption.
// A scoreboard predicts kind and error per token and checks each result in
// order. Random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module literal_token_classifier_test;
    import ltc_pkg::*;

    localparam int CHAR_TARGET  = 1300;
    localparam int QUIET_FROM   = 1150;  // no idling past this many words
    localparam int HOLD_AT      = 450;
    localparam int HOLD_CYCLES  = 90;
    localparam int STALL_LIMIT  = 1000;  // cycles with no word moving
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] err;
    } verdict_t;

    class token_verdict_board;
        logic [1:0] pos;
        logic [1:0] lead;
        logic [1:0] mode;
        logic       dot;
        logic [3:0] flags;
        verdict_t   pending_verdicts[$];
        int         failures;

        function new();
            failures = 0;
            clear();
        endfunction

        function void clear();
            pos   = 2'd0;
            lead  = LEAD_OTHER;
            mode  = MODE_DEC;
            dot   = 1'b0;
            flags = 4'd0;
        endfunction

        function bit numeral(logic [7:0] ch);
            return ch >= CH_ZERO && ch <= CH_NINE;
        endfunction

        function bit alpha_like(logic [7:0] ch);
            return (ch >= CH_LC_A && ch <= CH_LC_Z) || (ch >= CH_UC_A && ch <= CH_UC_Z)
                || ch == CH_UNDER;
        endfunction

        function bit hexit(logic [7:0] ch);
            return numeral(ch) || (ch >= CH_LC_A && ch <= CH_LC_F)
                || (ch >= CH_UC_A && ch <= CH_UC_F);
        endfunction

        function verdict_t close_token();
            verdict_t v;
            v.kind = KIND_NONE;
            v.err  = ERR_OK;
            if (lead == LEAD_ALPHA) begin
                if (flags[FLAG_PRE]) v.err = ERR_WORD;
                else v.kind = KIND_WORD;
            end else if (lead != LEAD_OTHER) begin
                if (dot) begin
                    // non-digit ahead of the dot outranks one after it
                    if (flags[FLAG_PRE]) v.err = ERR_FLOAT_PRE;
                    else if (flags[FLAG_POST]) v.err = ERR_FLOAT_POST;
                    else v.kind = KIND_FLOAT;
                end else if (mode == MODE_BIN) begin
                    if (flags[FLAG_BIN]) v.err = ERR_BIN;
                    else v.kind = KIND_BIN;
                end else if (mode == MODE_HEX) begin
                    if (flags[FLAG_HEX]) v.err = ERR_HEX;
                    else v.kind = KIND_HEX;
                end else begin
                    if (flags[FLAG_PRE]) v.err = ERR_DEC;
                    else v.kind = KIND_DEC;
                end
            end
            return v;
        endfunction

        function void take_char(logic [7:0] ch, logic last);
            if (pos == 2'd0) begin
                if (alpha_like(ch)) lead = LEAD_ALPHA;
                else if (ch == CH_ZERO) lead = LEAD_ZERO;
                else if (numeral(ch)) lead = LEAD_DIGIT;
                else lead = LEAD_OTHER;
            end else if (lead == LEAD_ALPHA) begin
                if (!alpha_like(ch) && !numeral(ch)) flags[FLAG_PRE] = 1'b1;
            end else if (lead != LEAD_OTHER) begin
                if (ch == CH_DOT && !dot) begin
                    dot = 1'b1;
                end else if (!numeral(ch)) begin
                    if (dot) flags[FLAG_POST] = 1'b1;
                    else flags[FLAG_PRE] = 1'b1;
                end
                if (pos == 2'd1) begin
                    // only lowercase prefix letters count
                    if (lead == LEAD_ZERO && ch == CH_LC_B) mode = MODE_BIN;
                    else if (lead == LEAD_ZERO && ch == CH_LC_X) mode = MODE_HEX;
                end else begin
                    if (ch != CH_ZERO && ch != CH_ONE) flags[FLAG_BIN] = 1'b1;
                    if (!hexit(ch)) flags[FLAG_HEX] = 1'b1;
                end
            end
            if (pos != POS_LAST) pos = pos + 2'd1;
            if (last) begin
                pending_verdicts.push_back(close_token());
                clear();
            end
        endfunction

        function void check_verdict(logic [2:0] kind, logic [2:0] got_err);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: kind %0d error %0d", kind, got_err);
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                failures++;
            end
            if (got_err !== want.err) begin
                $error("error: expected %0d, got %0d", want.err, got_err);
                failures++;
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_character;
    logic       s_last_char;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_kind;
    logic [2:0] m_error;

    token_verdict_board board = new();
    int sent_chars  = 0;
    int stall_count = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    bit sender_calm = 1'b0;

    literal_token_classifier dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_character(s_character),
        .s_last_char(s_last_char),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_error    (m_error)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // monitor: both channels sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) board.take_char(s_character, s_last_char);
        if (aresetn && m_valid && m_ready) board.check_verdict(m_kind, m_error);
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_count = 0;
        else stall_count = stall_count + 1;
    end

    initial begin
        wait (stall_count >= STALL_LIMIT);
        $display("literal_token_classifier: mismatch");
        $finish;
    end

    // result side: random stalls, plus one long hold so the input backs up
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
        end
    end

    task automatic pause_sender(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last);
        if (!quiet && !sender_calm && $urandom_range(0, 5) == 0)
            pause_sender($urandom_range(1, 7));
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_character <= ch;
        s_last_char <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_chars++;
        if (sent_chars >= QUIET_FROM) quiet = 1'b1;
        if (sent_chars >= HOLD_AT && !hold_done) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] letter_char();
        int n;
        n = $urandom_range(0, 52);
        if (n < 26) return 8'(CH_LC_A + n);
        if (n < 52) return 8'(CH_UC_A + (n - 26));
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] hex_char();
        int n;
        n = $urandom_range(0, 21);
        if (n < 10) return 8'(CH_ZERO + n);
        if (n < 16) return 8'(CH_LC_A + (n - 10));
        return 8'(CH_UC_A + (n - 16));
    endfunction

    task automatic send_random_token();
        logic [7:0] text[$];
        int body;
        int shape;
        body  = ($urandom_range(0, 29) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
        shape = $urandom_range(0, 9);
        sender_calm = ($urandom_range(0, 3) == 0);
        case (shape)
            0, 1: begin
                text.push_back(letter_char());
                repeat (body) text.push_back($urandom_range(0, 2) == 0 ? digit_char()
                                                                      : letter_char());
            end
            2: begin
                text.push_back($urandom_range(0, 3) == 0 ? CH_ZERO
                                                         : 8'(CH_ONE + $urandom_range(0, 8)));
                repeat (body) text.push_back(digit_char());
            end
            3: begin
                text.push_back(CH_ZERO);
                text.push_back(CH_LC_B);
                repeat (body) text.push_back(8'(CH_ZERO + $urandom_range(0, 1)));
            end
            4: begin
                text.push_back(CH_ZERO);
                text.push_back(CH_LC_X);
                repeat (body) text.push_back(hex_char());
            end
            5, 6: begin
                text.push_back(digit_char());
                repeat (body / 2) text.push_back(digit_char());
                text.push_back(CH_DOT);
                repeat (body - body / 2) text.push_back(digit_char());
            end
            7: begin
                // uppercase prefix letter, not a prefix at all
                text.push_back(CH_ZERO);
                text.push_back($urandom_range(0, 1) ? 8'h42 : 8'h58);
                repeat (body) text.push_back(hex_char());
            end
            default: begin
                repeat (body + 1) text.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        if ($urandom_range(0, 4) == 0)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            text.insert($urandom_range(1, text.size()), CH_DOT);
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_character = 8'd0;
        s_last_char = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_calm = 1'b1;
        send_text("_a9");
        send_text("0b");      // empty binary body
        send_text("0x");      // empty hex body
        send_text("0X1");
        send_text("1a.x");    // error before the dot wins
        send_text("0xg");
        send_text("0.5");
        send_text("1.2.");    // second dot
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(CH_LC_A, 1'b0);
        send_char(8'h80, 1'b1);

        while (sent_chars < CHAR_TARGET) send_random_token();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.failures == 0)
            $display("literal_token_classifier: match");
        else
            $display("literal_token_classifier: mismatch");
        $finish;
    end

endmodule
